[rtl/core/dcd_pkg.sv]
// Package for the door contact debouncer: codes, payload structs, sizing constants.
// No dependencies; every other file of the block but dcd_fifo refers to it by scoped names.

package dcd_pkg;

	// Width of a timestamp in milliseconds
	localparam int TimeBits = 48;

	// Default depths of the queue between front and back and of the result queue
	localparam int MidDepth = 2;
	localparam int OutDepth = 2;

	// Configuration register indexes
	localparam logic [1:0] CFG_DEBOUNCE_TIME    = 2'd0;
	localparam logic [1:0] CFG_UNSTABLE_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_CLOSED_POLARITY  = 2'd2;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_BACKWARDS = 2'd1,
		ERR_TIMEOUT   = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		DOOR_UNKNOWN = 2'd0,
		DOOR_CLOSED  = 2'd1,
		DOOR_OPEN    = 2'd2
	} door_t;

	typedef enum logic [1:0] {
		HEALTH_UNKNOWN = 2'd0,
		HEALTH_OK      = 2'd1,
		HEALTH_WARNING = 2'd2
	} health_t;

	typedef enum logic {
		REASON_NONE     = 1'b0,
		REASON_UNSTABLE = 1'b1
	} reason_t;

	// Raw sample as pushed by the user
	typedef struct packed {
		logic                level;
		logic [TimeBits-1:0] time_ms;
	} sample_t;

	// Sample after classification, as held between front and back
	typedef struct packed {
		logic                cfg_bad;
		logic                level;
		logic [TimeBits-1:0] time_ms;
	} mid_item_t;

	// Result snapshot
	typedef struct packed {
		err_t                error_code;
		door_t               door_state;
		health_t             health;
		reason_t             health_reason;
		logic [TimeBits-1:0] last_change_ms;
	} result_t;

	// Live configuration seen by front and back
	typedef struct packed {
		logic [15:0] debounce_time;
		logic [31:0] unstable_timeout;
		logic        closed_polarity;
	} cfg_t;

endpackage

[rtl/core/dcd_fifo.sv]
// Small first-in first-out queue of flip-flops, head shown combinationally.
// Generic in width and depth; used between front and back and for results.

module dcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntBits = $clog2(DEPTH + 1);
	localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
	localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

	logic [WIDTH-1:0]   mem_q [DEPTH];
	logic [PtrBits-1:0] wr_ptr_q;
	logic [PtrBits-1:0] rd_ptr_q;
	logic [CntBits-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/core/dcd_front.sv]
// Front of the debouncer: takes raw samples, flags a bad timeout setting, queues them.
// Depends on dcd_pkg and dcd_fifo.

module dcd_front #(
	parameter int DEPTH = dcd_pkg::MidDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dcd_pkg::cfg_t      cfg,
	input  logic               push,
	input  dcd_pkg::sample_t   sample,
	output logic               full,
	input  logic               take,
	output dcd_pkg::mid_item_t head,
	output logic               head_empty
);

	dcd_pkg::mid_item_t item;

	// Classify: a timeout below the debounce time rejects the sample outright
	always_comb begin
		item.cfg_bad = ({16'd0, cfg.debounce_time} > cfg.unstable_timeout);
		item.level   = sample.level;
		item.time_ms = sample.time_ms;
	end

	dcd_fifo #(
		.WIDTH($bits(dcd_pkg::mid_item_t)),
		.DEPTH(DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (item),
		.full  (full),
		.pop   (take),
		.rdata (head),
		.empty (head_empty)
	);

endmodule

[rtl/core/dcd_back.sv]
// Back of the debouncer: applies each sample to the debounce state, queues a snapshot.
// Depends on dcd_pkg and dcd_fifo.

module dcd_back #(
	parameter int DEPTH = dcd_pkg::OutDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dcd_pkg::cfg_t      cfg,
	input  dcd_pkg::mid_item_t head,
	input  logic               head_empty,
	output logic               take,
	input  logic               pop,
	output dcd_pkg::result_t   result,
	output logic               empty
);

	localparam int TB = dcd_pkg::TimeBits;

	logic             out_full;
	logic             go;
	dcd_pkg::result_t res;

	// Debounce state
	logic              seen_q, n_seen;
	logic [TB-1:0]     prev_q, n_prev;
	logic              acc_q, n_acc;
	logic              has_acc_q, n_has_acc;
	logic              in_tr_q, n_in_tr;
	logic              cand_level_q, n_cand_level;
	logic [TB-1:0]     cand_start_q, n_cand_start;
	logic [TB-1:0]     tr_start_q, n_tr_start;
	dcd_pkg::door_t    door_q, n_door;
	dcd_pkg::health_t  health_q, n_health;
	dcd_pkg::reason_t  reason_q, n_reason;
	logic [TB-1:0]     change_q, n_change;

	logic              fresh;
	logic              held;
	logic              stale;
	dcd_pkg::err_t     err;

	assign go   = !head_empty && !out_full;
	assign take = go;

	// Work out the next state for the sample at the head
	always_comb begin
		n_seen       = seen_q;
		n_prev       = prev_q;
		n_acc        = acc_q;
		n_has_acc    = has_acc_q;
		n_in_tr      = in_tr_q;
		n_cand_level = cand_level_q;
		n_cand_start = cand_start_q;
		n_tr_start   = tr_start_q;
		n_door       = door_q;
		n_health     = health_q;
		n_reason     = reason_q;
		n_change     = change_q;
		fresh        = 1'b0;
		held         = 1'b0;
		stale        = 1'b0;
		err          = dcd_pkg::ERR_NONE;
		if (head.cfg_bad) begin
			err = dcd_pkg::ERR_TIMEOUT;
		end else if (seen_q && (head.time_ms < prev_q)) begin
			err = dcd_pkg::ERR_BACKWARDS;
		end else begin
			n_prev = head.time_ms;
			n_seen = 1'b1;
			if (in_tr_q || !has_acc_q || (head.level != acc_q)) begin
				n_in_tr = 1'b1;
				fresh   = !in_tr_q || (head.level != cand_level_q);
				if (!in_tr_q) begin
					n_tr_start = head.time_ms;
				end
				if (fresh) begin
					n_cand_level = head.level;
					n_cand_start = head.time_ms;
				end
				// A fresh candidate has held for zero time
				held = fresh ? (cfg.debounce_time == '0)
					: ((head.time_ms - cand_start_q) >= TB'(cfg.debounce_time));
				stale = !in_tr_q ? (cfg.unstable_timeout == '0)
					: ((head.time_ms - tr_start_q) >= TB'(cfg.unstable_timeout));
				if (held) begin
					n_door    = (head.level == cfg.closed_polarity) ?
						dcd_pkg::DOOR_CLOSED : dcd_pkg::DOOR_OPEN;
					n_acc     = head.level;
					n_has_acc = 1'b1;
					n_in_tr   = 1'b0;
					n_health  = dcd_pkg::HEALTH_OK;
					n_reason  = dcd_pkg::REASON_NONE;
				end else if (stale) begin
					n_door   = dcd_pkg::DOOR_UNKNOWN;
					n_health = dcd_pkg::HEALTH_WARNING;
					n_reason = dcd_pkg::REASON_UNSTABLE;
				end
				if (n_door != door_q) begin
					n_change = head.time_ms;
				end
			end
		end
		res.error_code     = err;
		res.door_state     = n_door;
		res.health         = n_health;
		res.health_reason  = n_reason;
		res.last_change_ms = n_change;
	end

	// Commit state when the sample transfers to the result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			prev_q       <= '0;
			acc_q        <= 1'b0;
			has_acc_q    <= 1'b0;
			in_tr_q      <= 1'b0;
			cand_level_q <= 1'b0;
			cand_start_q <= '0;
			tr_start_q   <= '0;
			door_q       <= dcd_pkg::DOOR_UNKNOWN;
			health_q     <= dcd_pkg::HEALTH_UNKNOWN;
			reason_q     <= dcd_pkg::REASON_NONE;
			change_q     <= '0;
		end else if (go) begin
			seen_q       <= n_seen;
			prev_q       <= n_prev;
			acc_q        <= n_acc;
			has_acc_q    <= n_has_acc;
			in_tr_q      <= n_in_tr;
			cand_level_q <= n_cand_level;
			cand_start_q <= n_cand_start;
			tr_start_q   <= n_tr_start;
			door_q       <= n_door;
			health_q     <= n_health;
			reason_q     <= n_reason;
			change_q     <= n_change;
		end
	end

	dcd_fifo #(
		.WIDTH($bits(dcd_pkg::result_t)),
		.DEPTH(DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (go),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

[rtl/core/door_contact_debouncer.sv]
// Top level of the door contact debouncer: configuration registers, front and back.
// Depends on dcd_pkg, dcd_front, dcd_back (and through them dcd_fifo).
//
//   channel   handshake                 payload
//   --------  ------------------------  -----------------------------------
//   sample    push / full               sample   (level, time_ms)
//   result    pop / empty               result   (error_code .. last_change_ms)
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One sample per clock sustained while results are popped as they appear. A taken sample
// sits in the front queue, is applied to the state and written to the result queue once
// that queue has room, and is on the result ports once it reaches the head of that queue.
// Reset clears all state and loads the default configuration; no clearing pass.
// A stalled result side fills the result queue, then the front queue, then full rises.
// Configuration writes are always taken (cfg_ready is tied high).

module door_contact_debouncer #(
	parameter int MID_DEPTH = dcd_pkg::MidDepth,
	parameter int OUT_DEPTH = dcd_pkg::OutDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dcd_pkg::sample_t sample,
	output logic             full,
	input  logic             pop,
	output dcd_pkg::result_t result,
	output logic             empty,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	dcd_pkg::cfg_t      cfg_q;
	dcd_pkg::mid_item_t head;
	logic               head_empty;
	logic               take;
	logic               cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Hold configuration; write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time    <= 16'd50;
			cfg_q.unstable_timeout <= 32'd1000;
			cfg_q.closed_polarity  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				dcd_pkg::CFG_DEBOUNCE_TIME: begin
					cfg_q.debounce_time <= cfg_data[15:0];
				end
				dcd_pkg::CFG_UNSTABLE_TIMEOUT: begin
					cfg_q.unstable_timeout <= cfg_data;
				end
				dcd_pkg::CFG_CLOSED_POLARITY: begin
					cfg_q.closed_polarity <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	dcd_front #(
		.DEPTH(MID_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.sample    (sample),
		.full      (full),
		.take      (take),
		.head      (head),
		.head_empty(head_empty)
	);

	dcd_back #(
		.DEPTH(OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.head_empty(head_empty),
		.take      (take),
		.pop       (pop),
		.result    (result),
		.empty     (empty)
	);

endmodule

[sim/tb_door_contact_debouncer.sv]
// Self-checking testbench for door_contact_debouncer: directed and random sample streams.
// Depends on dcd_pkg and the block's RTL; an in-bench debounce model predicts each snapshot.

module tb_door_contact_debouncer;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	dcd_pkg::sample_t  sample_word = '0;
	logic              full;
	logic              pop = 1'b0;
	dcd_pkg::result_t  result_word;
	logic              empty;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = dcd_pkg::CFG_DEBOUNCE_TIME;
	logic [31:0]       cfg_data = '0;

	door_contact_debouncer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.sample   (sample_word),
		.full     (full),
		.pop      (pop),
		.result   (result_word),
		.empty    (empty),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Samples waiting to be offered, and snapshots predicted but not yet popped
	dcd_pkg::sample_t sample_backlog[$];
	dcd_pkg::result_t pending_snapshots[$];

	int mismatches = 0;
	int results_seen = 0;
	int cfg_xfers = 0;

	// Live register copy, as the block sees it
	logic [15:0] cfg_debounce = 16'd50;
	logic [31:0] cfg_timeout = 32'd1000;
	logic        cfg_closed_level = 1'b0;

	// Debounce state
	logic [dcd_pkg::TimeBits-1:0] last_time = '0;
	logic                         sample_seen = 1'b0;
	logic                         settled_level = 1'b0;
	logic                         have_settled = 1'b0;
	logic                         bouncing = 1'b0;
	logic                         cand_level = 1'b0;
	logic [dcd_pkg::TimeBits-1:0] cand_since = '0;
	logic [dcd_pkg::TimeBits-1:0] bounce_since = '0;
	dcd_pkg::door_t               door_now = dcd_pkg::DOOR_UNKNOWN;
	dcd_pkg::health_t             health_now = dcd_pkg::HEALTH_UNKNOWN;
	dcd_pkg::reason_t             reason_now = dcd_pkg::REASON_NONE;
	logic [dcd_pkg::TimeBits-1:0] door_changed_at = '0;

	// Stimulus generator state
	logic [dcd_pkg::TimeBits-1:0] stamp_ms = '0;
	logic                         gen_level = 1'b0;
	logic [15:0]                  gen_debounce = 16'd50;

	// Receiver long hold-off and a window with no idling on either side
	int   hold_left = 0;
	logic hold_used = 1'b0;
	logic burst_mode;
	assign burst_mode = results_seen >= 600 && results_seen < 800;

	task automatic move_door(input dcd_pkg::door_t next,
			input logic [dcd_pkg::TimeBits-1:0] now_ms);
		if (door_now != next)
			door_changed_at = now_ms;
		door_now = next;
	endtask

	// Advance the debounce state by one sample and build its snapshot
	task automatic debounce_sample(input dcd_pkg::sample_t s,
			output dcd_pkg::result_t snap);
		dcd_pkg::err_t err;
		err = dcd_pkg::ERR_NONE;
		if (cfg_timeout < {16'd0, cfg_debounce}) begin
			err = dcd_pkg::ERR_TIMEOUT;
		end else if (sample_seen && s.time_ms < last_time) begin
			err = dcd_pkg::ERR_BACKWARDS;
		end else begin
			last_time = s.time_ms;
			sample_seen = 1'b1;
			if (bouncing || !have_settled || s.level != settled_level) begin
				if (!bouncing) begin
					bouncing = 1'b1;
					bounce_since = s.time_ms;
					cand_since = s.time_ms;
					cand_level = s.level;
				end else if (s.level != cand_level) begin
					cand_level = s.level;
					cand_since = s.time_ms;
				end
				if (s.time_ms - cand_since >= cfg_debounce) begin
					// Candidate held long enough: accept it
					if (cand_level == cfg_closed_level)
						move_door(dcd_pkg::DOOR_CLOSED, s.time_ms);
					else
						move_door(dcd_pkg::DOOR_OPEN, s.time_ms);
					settled_level = cand_level;
					have_settled = 1'b1;
					bouncing = 1'b0;
					health_now = dcd_pkg::HEALTH_OK;
					reason_now = dcd_pkg::REASON_NONE;
				end else if (s.time_ms - bounce_since >= cfg_timeout) begin
					move_door(dcd_pkg::DOOR_UNKNOWN, s.time_ms);
					health_now = dcd_pkg::HEALTH_WARNING;
					reason_now = dcd_pkg::REASON_UNSTABLE;
				end
			end
		end
		snap.error_code = err;
		snap.door_state = door_now;
		snap.health = health_now;
		snap.health_reason = reason_now;
		snap.last_change_ms = door_changed_at;
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
			mismatches++;
		end
	endtask

	// Offer samples from the backlog, idling at random
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (sample_backlog.size() != 0 &&
				(burst_mode || $urandom_range(0, 99) >= 20)) begin
			push <= 1'b1;
			sample_word <= sample_backlog[0];
		end else begin
			push <= 1'b0;
		end
	end

	// Pop results, stalling at random and once for a long stretch
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else if (!hold_used && results_seen >= 400) begin
			hold_left <= 60;
			hold_used <= 1'b1;
			pop <= 1'b0;
		end else begin
			pop <= arst_n && (burst_mode || $urandom_range(0, 99) >= 20);
		end
	end

	// Track register writes, predict accepted samples, check popped results
	always @(posedge clk) begin : monitor
		dcd_pkg::result_t snap;
		dcd_pkg::result_t want;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dcd_pkg::CFG_DEBOUNCE_TIME:    cfg_debounce = cfg_data[15:0];
				dcd_pkg::CFG_UNSTABLE_TIMEOUT: cfg_timeout = cfg_data;
				dcd_pkg::CFG_CLOSED_POLARITY:  cfg_closed_level = cfg_data[0];
				default: ;
			endcase
			cfg_xfers++;
		end
		if (push && !full) begin
			debounce_sample(sample_word, snap);
			pending_snapshots.push_back(snap);
			if (sample_backlog.size() != 0)
				void'(sample_backlog.pop_front());
		end
		if (pop && !empty) begin
			results_seen++;
			if (pending_snapshots.size() == 0) begin
				$error("result transfer with no sample outstanding");
				mismatches++;
			end else begin
				want = pending_snapshots.pop_front();
				check_field("error_code", want.error_code, result_word.error_code);
				check_field("door_state", want.door_state, result_word.door_state);
				check_field("health", want.health, result_word.health);
				check_field("health_reason", want.health_reason, result_word.health_reason);
				check_field("last_change_ms", want.last_change_ms,
					result_word.last_change_ms);
			end
		end
	end

	task automatic queue_sample(input logic lvl, input logic [dcd_pkg::TimeBits-1:0] t);
		dcd_pkg::sample_t s;
		s.level = lvl;
		s.time_ms = t;
		sample_backlog.push_back(s);
	endtask

	task automatic write_setting(input logic [1:0] idx, input logic [31:0] data);
		int target;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		target = cfg_xfers + 1;
		do @(negedge clk); while (cfg_xfers != target);
		cfg_valid <= 1'b0;
	endtask

	// Write all three registers; unused upper data bits carry noise
	task automatic apply_settings(input logic [15:0] deb, input logic [31:0] tmo,
			input logic pol);
		write_setting(dcd_pkg::CFG_DEBOUNCE_TIME, {16'($urandom), deb});
		write_setting(dcd_pkg::CFG_UNSTABLE_TIMEOUT, tmo);
		write_setting(dcd_pkg::CFG_CLOSED_POLARITY, {31'($urandom), pol});
		gen_debounce = deb;
	endtask

	// Wait until every sample is taken and every snapshot checked
	task automatic drain();
		while (sample_backlog.size() != 0 || pending_snapshots.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly forward-moving streams with bursts of bouncing; a few backward stamps
	task automatic queue_random_samples(input int count);
		int                           n;
		int                           roll;
		int                           flip_pct;
		logic [31:0]                  span;
		logic [dcd_pkg::TimeBits-1:0] t;
		flip_pct = 30;
		for (n = 0; n < count; n++) begin
			if (n % 20 == 0) begin
				case ($urandom_range(0, 2))
					0: flip_pct = 5;
					1: flip_pct = 30;
					default: flip_pct = 75;
				endcase
			end
			roll = $urandom_range(0, 99);
			if (roll < 4 && stamp_ms != 0) begin
				t = stamp_ms - 48'd1 - 48'({$urandom, $urandom} % stamp_ms);
				queue_sample(1'($urandom), t);
			end else begin
				span = (roll < 14) ? 3 * gen_debounce + 10 : gen_debounce / 2 + 2;
				stamp_ms = stamp_ms + 48'($urandom_range(0, span));
				if ($urandom_range(0, 99) < flip_pct)
					gen_level = ~gen_level;
				queue_sample(gen_level, stamp_ms);
			end
		end
	endtask

	initial begin : stimulus
		int          phase;
		logic [15:0] deb;
		logic [31:0] tmo;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default settings: first sample, settle, bounce back, backward stamp
		queue_sample(1'b0, 48'd0);
		queue_sample(1'b0, 48'd30);
		queue_sample(1'b0, 48'd50);
		queue_sample(1'b0, 48'd60);
		queue_sample(1'b1, 48'd70);
		queue_sample(1'b0, 48'd80);
		queue_sample(1'b0, 48'd100);
		queue_sample(1'b0, 48'd130);
		queue_sample(1'b0, 48'd120);
		queue_sample(1'b1, 48'd200);
		queue_sample(1'b1, 48'd250);
		queue_sample(1'b0, 48'd250);
		drain();

		// Short timeout: bounce into unknown, then settle under flipped polarity
		apply_settings(16'd20, 32'd30, 1'b1);
		queue_sample(1'b1, 48'd260);
		queue_sample(1'b0, 48'd270);
		queue_sample(1'b1, 48'd280);
		queue_sample(1'b1, 48'd300);
		drain();

		// Zero debounce accepts on the opening sample
		apply_settings(16'd0, 32'd1, 1'b1);
		queue_sample(1'b0, 48'd300);
		queue_sample(1'b1, 48'd300);
		queue_sample(1'b0, 48'd301);
		drain();

		// Timeout below debounce rejects everything, ahead of the time check
		apply_settings(16'hFFFF, 32'd1, 1'b0);
		queue_sample(1'b1, 48'd400);
		queue_sample(1'b0, 48'd10);
		drain();

		// Largest debounce and timeout
		apply_settings(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		queue_sample(1'b1, 48'd1000);
		queue_sample(1'b1, 48'd66534);
		queue_sample(1'b1, 48'd66535);
		drain();

		// Jump the timestamp high so upper bits toggle, then random phases
		stamp_ms = 48'd66535 + {1'b0, 15'($urandom), 32'($urandom)};
		gen_level = 1'b1;
		for (phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 9))
				0: deb = 16'd0;
				1: deb = 16'd1;
				2: deb = 16'hFFFF;
				default: deb = 16'($urandom_range(2, 40));
			endcase
			case ($urandom_range(0, 9))
				0: tmo = (deb != 0) ? deb - 32'd1 : 32'd0;
				1: tmo = 32'hFFFF_FFFF;
				2: tmo = {16'd0, deb};
				default: tmo = deb + $urandom_range(1, 4 * deb + 20);
			endcase
			apply_settings(deb, tmo, 1'($urandom));
			queue_random_samples(137);
			drain();
		end

		// Top of the timestamp range, then one stamp behind it
		apply_settings(16'd1, 32'd1, 1'b1);
		queue_sample(~gen_level, {dcd_pkg::TimeBits{1'b1}});
		queue_sample(gen_level, 48'($urandom));
		drain();

		if (mismatches == 0)
			$display("door_contact_debouncer regression: pass");
		else
			$display("door_contact_debouncer regression: fail");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2000000;
		$display("door_contact_debouncer regression: fail");
		$finish;
	end

endmodule

[door_contact_debouncer.f]
rtl/core/dcd_pkg.sv
rtl/core/dcd_fifo.sv
rtl/core/dcd_front.sv
rtl/core/dcd_back.sv
rtl/core/door_contact_debouncer.sv
sim/tb_door_contact_debouncer.sv
